>>> rtl/spq_pkg.sv
// Package: widths, scale table, config codes and helpers for the scale pitch quantizer.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int PITCH_W       = 15;
    localparam int NOTE_W        = 7;
    localparam int SCALE_W       = 5;
    localparam int ROOT_W        = 7;
    localparam int CFG_DATA_W    = 7;
    localparam int CFG_IDX_W     = 1;
    localparam int DEG_N         = 12;
    localparam int TABLE_SCALES  = 25;

    localparam int NUM_SCALES_DEF = 25;
    localparam int FRAC_BITS_DEF  = 8;

    localparam logic [ROOT_W-1:0] ROOT_RESET = 7'd69;

    // x / 3 == (x * DIV3_MUL) >> DIV3_SHIFT for x < 2**17
    localparam logic [15:0] DIV3_MUL   = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NOTE    = 1'b1;

    typedef logic [DEG_N-1:0] deg_mask_t;
    typedef logic [3:0]       pc_t;

    typedef struct packed {
        deg_mask_t mask;
        pc_t       root_pc;
    } spq_cfg_t;

    localparam deg_mask_t SCALE_MASKS [TABLE_SCALES] = '{
        12'hAB5, 12'h5AD, 12'h2A5, 12'h6AD, 12'h5AB, 12'hAD5, 12'h6B5, 12'h56B, 12'h555,
        12'hFFF, 12'h4E9, 12'h9AD, 12'hAAD, 12'h9B3, 12'h5B3, 12'h9B3, 12'h4CB, 12'hAB3,
        12'h9A3, 12'h5AB, 12'hAB3, 12'hEB5, 12'hEAD, 12'hB35, 12'h6B5
    };

    // note mod 12 by conditional subtraction
    function automatic pc_t pitch_class(input logic [ROOT_W-1:0] note);
        logic [ROOT_W-1:0] v;
        v = note;
        if (v >= 7'd96) v = v - 7'd96;
        if (v >= 7'd48) v = v - 7'd48;
        if (v >= 7'd24) v = v - 7'd24;
        if (v >= 7'd12) v = v - 7'd12;
        return v[3:0];
    endfunction

    // width of (integer semitones + 12 - root class)
    function automatic int x_width(input int frac_bits);
        return (PITCH_W - frac_bits + 1 > 5) ? (PITCH_W - frac_bits + 1) : 5;
    endfunction

    // width of the octave index plus one
    function automatic int q_width(input int frac_bits);
        return x_width(frac_bits) - 3;
    endfunction

    // width of the in-octave offset (degree plus fraction)
    function automatic int off_width(input int frac_bits);
        return 4 + frac_bits;
    endfunction

endpackage

>>> rtl/spq_if.sv
// Interfaces: pitch input channel and quantized note output channel.
`timescale 1ns / 1ps

interface spq_pitch_if
    import spq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PITCH_W-1:0] pitch_q8;

    modport source (output valid, output pitch_q8, input ready);
    modport sink   (input valid, input pitch_q8, output ready);
endinterface

interface spq_note_if
    import spq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [NOTE_W-1:0] note_out;
    logic              was_clamped;

    modport source (output valid, output note_out, output was_clamped, input ready);
    modport sink   (input valid, input note_out, input was_clamped, output ready);
endinterface

>>> rtl/spq_cfg.sv
// Configuration registers: selected degree mask and root pitch class.
`timescale 1ns / 1ps

module spq_cfg
    import spq_pkg::*;
#(
    parameter int NUM_SCALES = NUM_SCALES_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output spq_cfg_t              cfg
);

    deg_mask_t mask_reg, mask_next;
    pc_t       pc_reg, pc_next;
    logic [SCALE_W:0] sel_wide;

    assign sel_wide = {1'b0, cfg_data[SCALE_W-1:0]};

    always_comb
    begin
        mask_next = mask_reg;
        pc_next   = pc_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCALE_SELECT:
                begin
                    // out-of-range selects fall back to the first scale
                    if (sel_wide < (SCALE_W + 1)'(NUM_SCALES)
                        && sel_wide < (SCALE_W + 1)'(TABLE_SCALES))
                        mask_next = SCALE_MASKS[cfg_data[SCALE_W-1:0]];
                    else
                        mask_next = SCALE_MASKS[0];
                end
                CFG_ROOT_NOTE:
                    pc_next = pitch_class(cfg_data[ROOT_W-1:0]);
                default:
                begin
                    mask_next = mask_reg;
                    pc_next   = pc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= SCALE_MASKS[0];
            pc_reg   <= pitch_class(ROOT_RESET);
        end
        else
        begin
            mask_reg <= mask_next;
            pc_reg   <= pc_next;
        end
    end

    assign cfg.mask    = mask_reg;
    assign cfg.root_pc = pc_reg;

endmodule

>>> rtl/spq_octave.sv
// Stage 1: input register, octave index from the root class and offset within the octave.
`timescale 1ns / 1ps

module spq_octave
    import spq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                            clk,
    input  logic                            rst_n,
    spq_pitch_if.sink                       pitch_stream,
    input  pc_t                             root_pc,
    output logic                            oct_valid,
    input  logic                            oct_ready,
    output logic [q_width(FRAC_BITS)-1:0]   oct_q,
    output logic [off_width(FRAC_BITS)-1:0] oct_off
);

    localparam int IP_W   = PITCH_W - FRAC_BITS;
    localparam int X_W    = x_width(FRAC_BITS);
    localparam int Y_W    = X_W - 2;
    localparam int PROD_W = Y_W + 16;
    localparam int Q_W    = q_width(FRAC_BITS);
    localparam int OFF_W  = off_width(FRAC_BITS);
    localparam logic [PITCH_W-1:0] P_MASK = PITCH_W'((1 << FRAC_BITS) - 1);

    logic               valid_reg, valid_next;
    logic [PITCH_W-1:0] pitch_reg;
    logic               load;

    logic [IP_W-1:0]   ip;
    logic [X_W-1:0]    x;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q;
    logic [X_W-1:0]    rem;

    assign pitch_stream.ready = !valid_reg || oct_ready;
    assign load               = pitch_stream.valid && pitch_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (pitch_stream.ready)
            valid_next = pitch_stream.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            pitch_reg <= pitch_stream.pitch_q8;
    end

    // x = semitones + 12 - root class, never negative; q = x / 12 = octave + 1
    assign ip   = IP_W'(pitch_reg >> FRAC_BITS);
    assign x    = X_W'(ip) + X_W'(DEG_N) - X_W'(root_pc);
    assign prod = PROD_W'(x[X_W-1:2]) * PROD_W'(DIV3_MUL);
    assign q    = prod[PROD_W-1:DIV3_SHIFT];
    assign rem  = x - (X_W'(q) << 3) - (X_W'(q) << 2);

    assign oct_valid = valid_reg;
    assign oct_q     = q;
    assign oct_off   = (OFF_W'(rem[3:0]) << FRAC_BITS) | OFF_W'(pitch_reg & P_MASK);

endmodule

>>> rtl/spq_snap.sv
// Stage 2: nearest scale degree below and above the offset, pick, clamp, output register.
`timescale 1ns / 1ps

module spq_snap
    import spq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                            clk,
    input  logic                            rst_n,
    input  spq_cfg_t                        cfg,
    input  logic                            oct_valid,
    output logic                            oct_ready,
    input  logic [q_width(FRAC_BITS)-1:0]   oct_q,
    input  logic [off_width(FRAC_BITS)-1:0] oct_off,
    spq_note_if.source                      note_stream
);

    localparam int Q_W    = q_width(FRAC_BITS);
    localparam int OFF_W  = off_width(FRAC_BITS);
    localparam int BEST_W = Q_W + 6;

    logic             mid_valid_reg, mid_valid_next;
    logic [Q_W-1:0]   q_reg;
    logic [OFF_W-1:0] off_reg;

    logic              out_valid_reg, out_valid_next;
    logic [NOTE_W-1:0] note_reg, note_next;
    logic              clamp_reg, clamp_next;
    logic              out_free;

    logic [3:0]        deg_pos;
    logic              has_lo;
    logic [3:0]        d_lo, d_hi, d_sel;
    logic [OFF_W-1:0]  dist_lo, dist_hi;
    logic [BEST_W-1:0] best;

    assign out_free  = !out_valid_reg || note_stream.ready;
    assign oct_ready = !mid_valid_reg || out_free;

    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        out_valid_next = out_valid_reg;
        if (oct_ready)
            mid_valid_next = oct_valid;
        if (out_free)
            out_valid_next = mid_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oct_ready && oct_valid)
        begin
            q_reg   <= oct_q;
            off_reg <= oct_off;
        end
        if (out_free && mid_valid_reg)
        begin
            note_reg  <= note_next;
            clamp_reg <= clamp_next;
        end
    end

    assign deg_pos = off_reg[OFF_W-1:FRAC_BITS];

    // highest scale degree at or below the offset, lowest above it (next root always there)
    always_comb
    begin
        has_lo = 1'b0;
        d_lo   = 4'd0;
        d_hi   = 4'(DEG_N);
        for (int d = 0; d < DEG_N; d++)
        begin
            if (cfg.mask[d] && 4'(d) <= deg_pos)
            begin
                has_lo = 1'b1;
                d_lo   = 4'(d);
            end
        end
        for (int d = DEG_N - 1; d >= 0; d--)
        begin
            if (cfg.mask[d] && 4'(d) > deg_pos)
                d_hi = 4'(d);
        end
    end

    assign dist_lo = off_reg - (OFF_W'(d_lo) << FRAC_BITS);
    assign dist_hi = (OFF_W'(d_hi) << FRAC_BITS) - off_reg;

    // equal distance goes to the lower note
    assign d_sel = (has_lo && dist_lo <= dist_hi) ? d_lo : d_hi;

    // note = (q - 1) * 12 + root class + degree, may dip below zero
    assign best = (BEST_W'(q_reg) << 3) + (BEST_W'(q_reg) << 2) + BEST_W'(cfg.root_pc)
                  + BEST_W'(d_sel) - BEST_W'(DEG_N);

    always_comb
    begin
        if (best[BEST_W-1])
        begin
            note_next  = '0;
            clamp_next = 1'b1;
        end
        else if (best > BEST_W'(NOTE_MAX))
        begin
            note_next  = NOTE_MAX;
            clamp_next = 1'b1;
        end
        else
        begin
            note_next  = best[NOTE_W-1:0];
            clamp_next = 1'b0;
        end
    end

    assign note_stream.valid       = out_valid_reg;
    assign note_stream.note_out    = note_reg;
    assign note_stream.was_clamped = clamp_reg;

endmodule

>>> rtl/scale_pitch_quantizer_core.sv
// Top level: scale pitch quantizer, config registers and two-stage datapath.
`timescale 1ns / 1ps

// Snaps a pitch (semitones, FRAC_BITS fraction bits) to the nearest note of the
// selected scale anchored at the root's pitch class; ties go to the lower note.
// Channels: pitch_stream takes one item (pitch_q8) per valid&ready edge;
// note_stream returns one item (note_out, was_clamped) per input, in order.
// Config: cfg_we with cfg_index 0 = scale_select, 1 = root_note; write only
// while no items are in flight. Scale/root are decoded into a mask and pitch
// class at write time.
// Path: an item accepted on pitch_stream passes the input, octave and result
// registers in that order and then shows on note_stream (valid high).
// Throughput: one item per cycle while note_stream is ready, set by
// the octave divide-by-12 (reciprocal multiply) and the degree pick, each
// between two registers.
// Stall: each stage holds while the one after it is full; the result register
// keeps the last item until taken and upstream stages keep filling, so up to
// three items sit in the block before pitch_stream.ready drops.
// Reset: all stages empty, scale 0 (major), root class 9 (note 69).

module scale_pitch_quantizer_core
    import spq_pkg::*;
#(
    parameter int NUM_SCALES = NUM_SCALES_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    spq_pitch_if.sink             pitch_stream,
    spq_note_if.source            note_stream
);

    spq_cfg_t cfg;

    logic                            oct_valid;
    logic                            oct_ready;
    logic [q_width(FRAC_BITS)-1:0]   oct_q;
    logic [off_width(FRAC_BITS)-1:0] oct_off;

    spq_cfg #(
        .NUM_SCALES (NUM_SCALES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage 1: octave index and in-octave offset
    spq_octave #(
        .FRAC_BITS (FRAC_BITS)
    ) u_octave (
        .clk          (clk),
        .rst_n        (rst_n),
        .pitch_stream (pitch_stream),
        .root_pc      (cfg.root_pc),
        .oct_valid    (oct_valid),
        .oct_ready    (oct_ready),
        .oct_q        (oct_q),
        .oct_off      (oct_off)
    );

    // stage 2: degree pick, clamp, result register
    spq_snap #(
        .FRAC_BITS (FRAC_BITS)
    ) u_snap (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .oct_valid   (oct_valid),
        .oct_ready   (oct_ready),
        .oct_q       (oct_q),
        .oct_off     (oct_off),
        .note_stream (note_stream)
    );

endmodule
